>>> hdl/lbs_pkg.sv
`timescale 1ns / 1ps

package lbs_pkg;

  localparam int TDATA_IN_W  = 160;
  localparam int TDATA_OUT_W = 128;

  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_WEIGHT = 2'd1;
  localparam logic [1:0] MODE_PASS   = 2'd2;

  typedef struct packed {
    logic       capture;  // latch the accepted item
    logic       wr;       // write the accepted matrix element
    logic       issue;    // read one matrix row and start its pipeline pass
    logic       add;      // the issued row contributes to the accumulators
    logic [1:0] row;      // matrix row being issued
    logic       emit;     // load the blended result and clear the accumulators
    logic       pass;     // load the pass-through result
  } lbs_cmd_t;

endpackage

>>> hdl/lbs_ram.sv
`timescale 1ns / 1ps

module lbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/lbs_ctrl.sv
`timescale 1ns / 1ps

module lbs_ctrl #(
  parameter int MAX_JOINTS = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_mode,
  input  logic [5:0]       in_joint,
  input  logic             in_last,
  input  logic             out_free,
  output lbs_pkg::lbs_cmd_t cmd
);

  import lbs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_EMIT,
    ST_PASS
  } state_t;

  state_t     state;
  logic [1:0] row;
  logic [1:0] drain;
  logic       item_last;
  logic       item_add;
  logic       joint_ok;
  logic       accept;

  always_comb begin
    joint_ok    = {3'b000, in_joint} < 9'(MAX_JOINTS);
    in_ready    = (state == ST_IDLE) || (state == ST_RUN && row == 2'd3 && !item_last);
    accept      = in_valid && in_ready;
    cmd.capture = accept;
    cmd.wr      = accept && (in_mode == MODE_LOAD) && joint_ok;
    cmd.issue   = (state == ST_RUN);
    cmd.add     = item_add;
    cmd.row     = row;
    cmd.emit    = (state == ST_EMIT) && out_free;
    cmd.pass    = (state == ST_PASS) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      row       <= 2'd0;
      drain     <= 2'd0;
      item_last <= 1'b0;
      item_add  <= 1'b0;
    end else begin
      if (accept) begin
        item_last <= in_last;
        item_add  <= joint_ok;
      end
      unique case (state)
        ST_IDLE, ST_RUN: begin
          if (state == ST_RUN && row != 2'd3) begin
            row <= row + 2'd1;
          end else if (accept) begin
            priority if (in_mode == MODE_WEIGHT) begin
              state <= ST_RUN;
              row   <= 2'd0;
            end else if (in_mode == MODE_PASS) begin
              state <= ST_PASS;
            end else begin
              state <= ST_IDLE;
            end
          end else if (state == ST_RUN && item_last) begin
            // let the last rows reach the accumulators
            state <= ST_DRAIN;
            drain <= 2'd0;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_DRAIN: begin
          drain <= drain + 2'd1;
          if (drain == 2'd3) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT, ST_PASS: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_weight_starts_row0: assert property (@(posedge clk) disable iff (rst)
    accept && in_mode == MODE_WEIGHT |=> cmd.issue && cmd.row == 2'd0)
    else $error("weight item did not start at row 0");

  a_last_reaches_emit: assert property (@(posedge clk) disable iff (rst)
    cmd.issue && cmd.row == 2'd3 && item_last |=> !in_ready ##4 state == ST_EMIT)
    else $error("last term did not drain into emit");

  a_write_outside_rows: assert property (@(posedge clk) disable iff (rst)
    cmd.wr |-> !cmd.issue || cmd.row == 2'd3)
    else $error("table write in the middle of a row sweep");
`endif

endmodule

>>> hdl/lbs_datapath.sv
`timescale 1ns / 1ps

module lbs_datapath #(
  parameter int MAX_JOINTS = 64,
  parameter int FRAC_BITS  = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  lbs_pkg::lbs_cmd_t                  cmd,
  input  logic [lbs_pkg::TDATA_IN_W-1:0]     in_data,
  output logic [lbs_pkg::TDATA_OUT_W-1:0]    out_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_free
);

  import lbs_pkg::*;

  localparam int W_FRAC = 15;
  localparam int BAW    = $clog2(MAX_JOINTS * 4);
  localparam logic [31:0] ONE = 32'(1) << FRAC_BITS;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if ((&v[65:31]) || !(|v[65:31])) begin
      return v[31:0];
    end
    return v[65] ? 32'h8000_0000 : 32'h7FFF_FFFF;
  endfunction

  // input fields
  logic [5:0]  in_joint;
  logic [3:0]  in_elem;
  logic [31:0] in_value;

  assign in_joint = in_data[5:0];
  assign in_elem  = in_data[9:6];
  assign in_value = in_data[41:10];

  // held item
  logic [5:0]         it_joint;
  logic signed [31:0] it_x, it_y, it_z;
  logic [15:0]        it_w;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      it_joint <= in_joint;
      it_x     <= in_data[73:42];
      it_y     <= in_data[105:74];
      it_z     <= in_data[137:106];
      it_w     <= in_data[153:138];
    end
  end

  // matrix table: one bank per column, one row read per cycle
  logic [BAW+7:0] waddr_w, raddr_w;
  logic [BAW-1:0] waddr, raddr;
  logic [31:0]    mrow [4];

  assign waddr_w = {BAW'(0), in_joint, in_elem[3:2]};
  assign raddr_w = {BAW'(0), it_joint, cmd.row};
  assign waddr   = waddr_w[BAW-1:0];
  assign raddr   = raddr_w[BAW-1:0];

  for (genvar b = 0; b < 4; b++) begin : g_bank
    lbs_ram #(
      .WIDTH(32),
      .DEPTH(MAX_JOINTS * 4)
    ) u_bank (
      .clk  (clk),
      .we   (cmd.wr && in_elem[1:0] == 2'(b)),
      .waddr(waddr),
      .wdata(in_value),
      .raddr(raddr),
      .rdata(mrow[b])
    );
  end

  // stage 1: alongside the table read
  logic               en1;
  logic [1:0]         row1;
  logic signed [31:0] x1, y1, z1;
  logic [15:0]        w1;

  // stage 2: column products
  logic               en2;
  logic [1:0]         row2;
  logic signed [63:0] p2 [3];
  logic signed [31:0] m3_2;
  logic [15:0]        w2;
  logic signed [63:0] prod [3];

  // stage 3: saturated row value
  logic               en3;
  logic [1:0]         row3;
  logic signed [31:0] rv3;
  logic [15:0]        w3;
  logic signed [65:0] e0, e1, e2, m3e, rsum;

  // stage 4: weighted row value
  logic               en4;
  logic [1:0]         row4;
  logic signed [48:0] wp4;
  logic signed [48:0] wprod;

  logic signed [63:0] acc [4];
  logic signed [64:0] asum;

  assign prod[0] = $signed(mrow[0]) * x1;
  assign prod[1] = $signed(mrow[1]) * y1;
  assign prod[2] = $signed(mrow[2]) * z1;

  // arithmetic shift rounds toward minus infinity
  assign e0   = $signed({{2{p2[0][63]}}, p2[0]}) >>> FRAC_BITS;
  assign e1   = $signed({{2{p2[1][63]}}, p2[1]}) >>> FRAC_BITS;
  assign e2   = $signed({{2{p2[2][63]}}, p2[2]}) >>> FRAC_BITS;
  assign m3e  = $signed({{34{m3_2[31]}}, m3_2});
  assign rsum = e0 + e1 + e2 + m3e;

  assign wprod = rv3 * $signed({1'b0, w3});
  assign asum  = $signed({acc[row4][63], acc[row4]}) + $signed({{16{wp4[48]}}, wp4});

  always_ff @(posedge clk) begin
    if (rst) begin
      en1 <= 1'b0;
      en2 <= 1'b0;
      en3 <= 1'b0;
      en4 <= 1'b0;
    end else begin
      en1 <= cmd.issue && cmd.add;
      en2 <= en1;
      en3 <= en2;
      en4 <= en3;
    end
    row1 <= cmd.row;
    x1   <= it_x;
    y1   <= it_y;
    z1   <= it_z;
    w1   <= it_w;
    row2 <= row1;
    p2   <= prod;
    m3_2 <= $signed(mrow[3]);
    w2   <= w1;
    row3 <= row2;
    rv3  <= sat32(rsum);
    w3   <= w2;
    row4 <= row3;
    wp4  <= wprod;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.emit) begin
      for (int r = 0; r < 4; r++) begin
        acc[r] <= 64'sd0;
      end
    end else if (en4) begin
      if (asum[64] != asum[63]) begin
        acc[row4] <= asum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end else begin
        acc[row4] <= asum[63:0];
      end
    end
  end

  // result
  logic signed [63:0] sh [4];
  logic [31:0]        blend [4];

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      sh[r]    = acc[r] >>> W_FRAC;
      blend[r] = sat32($signed({{2{sh[r][63]}}, sh[r]}));
    end
  end

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit || cmd.pass) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.emit) begin
      out_data <= {blend[3], blend[2], blend[1], blend[0]};
    end else if (cmd.pass) begin
      out_data <= {ONE, it_z, it_y, it_x};
    end
  end

endmodule

>>> hdl/linear_blend_skinning_core.sv
`timescale 1ns / 1ps

// Linear blend skinning of one vertex in Q16.16 with Q1.15 weights. Load each
// joint's 4x4 skinning matrix element by element (mode 0, one element per
// cycle while idle), then send the vertex's weight terms (mode 1) with tlast
// on the final one; the blended (x, y, z, w) comes out as one item on that
// last term. The matrix table is four column banks, so one row is read per
// cycle: a weight term reads and multiplies its four rows, and the next one
// is accepted with the last row. The last term holds off the next item until
// the multiply/accumulate pipeline has drained and the result is loaded.
// Pass-through (mode 2) returns the position with w equal to one. The input
// side stays open while a finished result waits on the output register.
// Matrix elements read before being loaded give undefined results.
module linear_blend_skinning_core #(
  parameter int MAX_JOINTS = 64,
  parameter int FRAC_BITS  = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // joint[5:0], element[9:6], value[41:10], pos_x[73:42], pos_y[105:74],
  // pos_z[137:106], weight[153:138], zero fill [159:154]
  input  logic [159:0] s_axis_tdata,
  // mode[1:0]
  input  logic [1:0]   s_axis_tuser,
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_x[31:0], out_y[63:32], out_z[95:64], out_w[127:96]
  output logic [127:0] m_axis_tdata
);

  import lbs_pkg::*;

  lbs_cmd_t cmd;
  logic     out_free;

  lbs_ctrl #(
    .MAX_JOINTS(MAX_JOINTS)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_axis_tvalid),
    .in_ready(s_axis_tready),
    .in_mode (s_axis_tuser),
    .in_joint(s_axis_tdata[5:0]),
    .in_last (s_axis_tlast),
    .out_free(out_free),
    .cmd     (cmd)
  );

  lbs_datapath #(
    .MAX_JOINTS(MAX_JOINTS),
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_data  (s_axis_tdata),
    .out_data (m_axis_tdata),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_free (out_free)
  );

endmodule

>>> sim/linear_blend_skinning_core_tb.sv
`timescale 1ns / 1ps

module linear_blend_skinning_core_tb;
  import lbs_pkg::*;

  localparam int MAX_JOINTS  = 64;
  localparam int FRAC_BITS   = 16;
  localparam int W_FRAC      = 15;
  localparam int ITEMS       = 1500;
  localparam int HOLD_CYCLES = 400;
  localparam int QUIET_LIMIT = 4000;
  localparam int DRAIN_WAIT  = 24;

  localparam logic [1:0]         MODE_IGNORED = 2'd3;  // no operation, dropped by the block
  localparam logic signed [31:0] ONE_Q16      = 1 << FRAC_BITS;
  localparam logic signed [31:0] I32_MAX      = 32'sh7fffffff;
  localparam logic signed [31:0] I32_MIN      = 32'sh80000000;

  typedef struct {
    logic [1:0]         mode;
    logic [5:0]         joint;
    logic [3:0]         element;
    logic signed [31:0] value;
    logic signed [31:0] pos_x, pos_y, pos_z;
    logic [15:0]        weight;
    logic               last;
  } skin_item_t;

  typedef struct {
    logic signed [31:0] x, y, z, w;
  } skin_out_t;

  typedef struct {
    skin_item_t item;
    bit         typed;  // result is written in the row
    skin_out_t  res;
  } directed_row_t;

  logic                   clk;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [TDATA_IN_W-1:0]  s_axis_tdata;
  logic [1:0]             s_axis_tuser;
  logic                   s_axis_tlast;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [TDATA_OUT_W-1:0] m_axis_tdata;

  linear_blend_skinning_core #(
    .MAX_JOINTS(MAX_JOINTS),
    .FRAC_BITS (FRAC_BITS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // Predicted block state
  logic signed [31:0] mat_tbl    [MAX_JOINTS*16];
  logic signed [63:0] blend_acc  [4];
  skin_out_t          skinned_q  [$];

  int send_gap_pct   = 12;
  int recv_stall_pct = 50;
  bit hold_req       = 1'b0;
  int fed            = 0;
  int n_load         = 0;
  int n_term         = 0;
  int n_pass         = 0;
  int n_ignored      = 0;
  int results_seen   = 0;
  int mismatches     = 0;
  int quiet          = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic signed [31:0] clamp32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return I32_MAX;
    if (v < -64'sd2147483648) return I32_MIN;
    return v[31:0];
  endfunction

  function automatic logic signed [63:0] acc_add(logic signed [63:0] a,
                                                 logic signed [63:0] b);
    logic signed [64:0] s;
    s = a + b;
    if (s[64] != s[63]) return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    return s[63:0];
  endfunction

  // Update the predicted state with one item; return 1 when it yields a result.
  function automatic bit apply_skinning(skin_item_t it, output skin_out_t res);
    logic signed [63:0] pos [3];
    logic signed [63:0] row_sum, m64, prod;
    int base;
    res = '{0, 0, 0, 0};
    pos[0] = it.pos_x;
    pos[1] = it.pos_y;
    pos[2] = it.pos_z;
    base = it.joint * 16;
    case (it.mode)
      MODE_LOAD: begin
        if (it.joint < MAX_JOINTS) begin
          mat_tbl[base + it.element] = it.value;
        end
        return 1'b0;
      end
      MODE_PASS: begin
        res = '{it.pos_x, it.pos_y, it.pos_z, ONE_Q16};
        return 1'b1;
      end
      MODE_WEIGHT: begin
        if (it.joint < MAX_JOINTS) begin
          for (int r = 0; r < 4; r++) begin
            row_sum = mat_tbl[base + r*4 + 3];
            for (int c = 0; c < 3; c++) begin
              m64 = mat_tbl[base + r*4 + c];
              prod = m64 * pos[c];
              row_sum += prod >>> FRAC_BITS;
            end
            row_sum = clamp32(row_sum);
            blend_acc[r] = acc_add(blend_acc[r], row_sum * $signed({48'd0, it.weight}));
          end
        end
        if (!it.last) return 1'b0;
        res.x = clamp32(blend_acc[0] >>> W_FRAC);
        res.y = clamp32(blend_acc[1] >>> W_FRAC);
        res.z = clamp32(blend_acc[2] >>> W_FRAC);
        res.w = clamp32(blend_acc[3] >>> W_FRAC);
        for (int r = 0; r < 4; r++) blend_acc[r] = '0;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic skin_item_t make_item(logic [1:0] mode, logic [5:0] joint,
                                           logic [3:0] element, logic signed [31:0] value,
                                           logic signed [31:0] x, logic signed [31:0] y,
                                           logic signed [31:0] z, logic [15:0] weight,
                                           logic last);
    return '{mode, joint, element, value, x, y, z, weight, last};
  endfunction

  // Mostly values within +/- 2^(span-1), some full range, some at the rails.
  function automatic logic signed [31:0] rand_fixed(int span);
    case ($urandom_range(7))
      0: return $urandom;
      1: return $urandom_range(1) ? I32_MAX : I32_MIN;
      default: return $signed($urandom_range((1 << span) - 1, 0)) - (1 << (span - 1));
    endcase
  endfunction

  task automatic feed_item(skin_item_t it, bit typed, skin_out_t typed_res);
    skin_out_t res;
    bit        has;
    while ($urandom_range(99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, it.weight, it.pos_z, it.pos_y, it.pos_x, it.value,
                      it.element, it.joint};
    s_axis_tuser  <= it.mode;
    s_axis_tlast  <= it.last;
    do begin
      @(posedge clk);
    end while (!(s_axis_tvalid && s_axis_tready));
    has = apply_skinning(it, res);
    if (typed) skinned_q.push_back(typed_res);
    else if (has) skinned_q.push_back(res);
    case (it.mode)
      MODE_LOAD:   n_load++;
      MODE_WEIGHT: n_term++;
      MODE_PASS:   n_pass++;
      default:     n_ignored++;
    endcase
    if (it.mode != MODE_IGNORED) fed++;
  endtask

  // Output side: random stalls, plus one long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    skin_out_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64],
              m_axis_tdata[127:96]};
      results_seen++;
      if (skinned_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result %0d: (%0d %0d %0d %0d)", results_seen,
                   got.x, got.y, got.z, got.w);
      end else begin
        want = skinned_q.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.z !== want.z || got.w !== want.w) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: result %0d expected (%0d %0d %0d %0d) got (%0d %0d %0d %0d)",
                     results_seen, want.x, want.y, want.z, want.w,
                     got.x, got.y, got.z, got.w);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet == QUIET_LIMIT) begin
        $display("linear_blend_skinning_core verification failed");
        $finish;
      end
    end
  end

  initial begin
    directed_row_t directed [$];
    skin_item_t    it;
    int            ready_q [$];
    int            order [16];
    int            roll, n_terms, pick, tmp, j;
    logic [15:0]   w;
    bit            hold_done;

    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = MODE_LOAD;
    s_axis_tlast  = 1'b0;
    hold_done     = 1'b0;
    for (int r = 0; r < 4; r++) blend_acc[r] = '0;

    // Pass-through straight out of reset, position at the rails
    directed.push_back('{make_item(MODE_PASS, 6'd0, 4'd0, 0, I32_MAX, I32_MIN, 0, 16'd0, 1'b1),
                         1'b1, '{I32_MAX, I32_MIN, 32'sd0, ONE_Q16}});
    // Identity matrix on the highest joint
    for (int e = 0; e < 16; e++)
      directed.push_back('{make_item(MODE_LOAD, 6'd63, e[3:0], (e % 5 == 0) ? ONE_Q16 : 32'sd0,
                                     $urandom, $urandom, $urandom,
                                     16'($urandom_range(65535)), 1'($urandom_range(1))),
                           1'b0, '{0, 0, 0, 0}});
    // Full weight through identity returns the position
    directed.push_back('{make_item(MODE_WEIGHT, 6'd63, 4'd15, I32_MIN, I32_MAX, I32_MIN, -1,
                                   16'd32768, 1'b1), 1'b1, '{I32_MAX, I32_MIN, -32'sd1, ONE_Q16}});
    // Unused mode: dropped even with tlast set
    directed.push_back('{make_item(MODE_IGNORED, 6'd63, 4'd15, I32_MAX, 1, 2, 3, 16'hffff, 1'b1),
                         1'b0, '{0, 0, 0, 0}});
    // Half weight not last, then a pass-through that must not disturb the sum
    directed.push_back('{make_item(MODE_WEIGHT, 6'd63, 4'd0, 0, 32'sh10000, 32'sh20000,
                                   32'sh30000, 16'd16384, 1'b0), 1'b0, '{0, 0, 0, 0}});
    directed.push_back('{make_item(MODE_PASS, 6'd0, 4'd0, 0, 5, 6, 7, 16'd0, 1'b0),
                         1'b1, '{32'sd5, 32'sd6, 32'sd7, ONE_Q16}});
    // Weight above one, used unclamped
    directed.push_back('{make_item(MODE_WEIGHT, 6'd63, 4'd0, 0, $urandom, $urandom, $urandom,
                                   16'hffff, 1'b1), 1'b0, '{0, 0, 0, 0}});
    // Zero weight right after a cleared sum
    directed.push_back('{make_item(MODE_WEIGHT, 6'd63, 4'd0, 0, $urandom, $urandom, $urandom,
                                   16'd0, 1'b1), 1'b1, '{0, 0, 0, 0}});
    // Row sum saturates high, then low
    directed.push_back('{make_item(MODE_LOAD, 6'd63, 4'd3, I32_MAX, 0, 0, 0, 16'd0, 1'b0),
                         1'b0, '{0, 0, 0, 0}});
    directed.push_back('{make_item(MODE_WEIGHT, 6'd63, 4'd0, 0, I32_MAX, 0, 0, 16'd32768, 1'b1),
                         1'b1, '{I32_MAX, 32'sd0, 32'sd0, ONE_Q16}});
    directed.push_back('{make_item(MODE_LOAD, 6'd63, 4'd3, I32_MIN, 0, 0, 0, 16'd0, 1'b1),
                         1'b0, '{0, 0, 0, 0}});
    directed.push_back('{make_item(MODE_WEIGHT, 6'd63, 4'd0, 0, I32_MIN, I32_MAX, I32_MIN,
                                   16'd32768, 1'b1), 1'b0, '{0, 0, 0, 0}});

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) feed_item(directed[i].item, directed[i].typed, directed[i].res);
    ready_q.push_back(63);

    while (fed < ITEMS) begin
      if (fed < ITEMS / 3) begin
        send_gap_pct   = 12;
        recv_stall_pct = 50;
      end else if (fed < 2 * ITEMS / 3) begin
        send_gap_pct   = 50;
        recv_stall_pct = 12;
      end else begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        if (!hold_done) begin
          hold_req  = 1'b1;
          hold_done = 1'b1;
        end
      end

      roll = $urandom_range(99);
      if (roll < 10) begin
        // Load a whole matrix in shuffled element order
        j = $urandom_range(63);
        for (int e = 0; e < 16; e++) order[e] = e;
        for (int e = 15; e > 0; e--) begin
          pick = $urandom_range(e);
          tmp = order[e];
          order[e] = order[pick];
          order[pick] = tmp;
        end
        for (int e = 0; e < 16; e++)
          feed_item(make_item(MODE_LOAD, j[5:0], order[e][3:0], rand_fixed(18), $urandom,
                              $urandom, $urandom, 16'($urandom_range(65535)),
                              1'($urandom_range(1))),
                    1'b0, '{0, 0, 0, 0});
        ready_q.push_back(j);
      end else if (roll < 18) begin
        feed_item(make_item(MODE_PASS, 6'($urandom), 4'($urandom), $urandom, rand_fixed(24),
                            rand_fixed(24), rand_fixed(24), 16'($urandom),
                            1'($urandom_range(1))),
                  1'b0, '{0, 0, 0, 0});
      end else if (roll < 23) begin
        // Noise: stray element load or an unused mode
        if ($urandom_range(1))
          feed_item(make_item(MODE_IGNORED, 6'($urandom), 4'($urandom), $urandom, $urandom,
                              $urandom, $urandom, 16'($urandom), 1'($urandom_range(1))),
                    1'b0, '{0, 0, 0, 0});
        else
          feed_item(make_item(MODE_LOAD, 6'($urandom), 4'($urandom), rand_fixed(18), $urandom,
                              $urandom, $urandom, 16'($urandom), 1'($urandom_range(1))),
                    1'b0, '{0, 0, 0, 0});
      end else begin
        n_terms = ($urandom_range(9) == 0) ? $urandom_range(12, 5) : $urandom_range(4, 1);
        for (int t = 0; t < n_terms; t++) begin
          if ($urandom_range(19) == 0)
            feed_item(make_item(MODE_PASS, 6'($urandom), 4'($urandom), $urandom,
                                rand_fixed(24), rand_fixed(24), rand_fixed(24), 16'($urandom),
                                1'($urandom_range(1))),
                      1'b0, '{0, 0, 0, 0});
          case ($urandom_range(9))
            0:       w = 16'd0;
            1:       w = 16'd32768;
            2:       w = 16'($urandom_range(65535));
            default: w = 16'($urandom_range(32768));
          endcase
          it = make_item(MODE_WEIGHT, 6'(ready_q[$urandom_range(ready_q.size() - 1)]),
                         4'($urandom), $urandom, rand_fixed(24), rand_fixed(24), rand_fixed(24),
                         w, t == n_terms - 1);
          feed_item(it, 1'b0, '{0, 0, 0, 0});
        end
      end
    end
    s_axis_tvalid <= 1'b0;

    while (skinned_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Run fed %0d items: %0d matrix loads, %0d weight terms, %0d pass-throughs,",
             fed, n_load, n_term, n_pass);
    $display("%0d ignored items; %0d results checked, %0d mismatches",
             n_ignored, results_seen, mismatches);
    if (mismatches == 0 && skinned_q.size() == 0) begin
      $display("linear_blend_skinning_core verification clean");
    end else begin
      $display("linear_blend_skinning_core verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/lbs_pkg.sv
hdl/lbs_ram.sv
hdl/lbs_ctrl.sv
hdl/lbs_datapath.sv
hdl/linear_blend_skinning_core.sv
sim/linear_blend_skinning_core_tb.sv
